// ===== hw/rtl/swl_pkg.sv =====
// Shared types, constants and the seven-segment encoder for the lap stopwatch.
// No dependencies; every other file of the block imports this package.
package swl_pkg;

	localparam int TIME_W     = 19;
	localparam int WRAP_LIMIT = 360000;
	localparam int SEG_W      = 7;

	// Button bit positions within the poll
	localparam int BTN_START = 0;
	localparam int BTN_STOP  = 1;
	localparam int BTN_LAP   = 2;
	localparam int BTN_CLEAR = 3;
	localparam int BTN_W     = 4;

	localparam logic [TIME_W-1:0] WRAP_LAST = TIME_W'(WRAP_LIMIT - 1);

	typedef logic [3:0] digit_t;

	typedef struct packed {
		digit_t min_tens;
		digit_t min_units;
		digit_t sec_tens;
		digit_t sec_units;
		digit_t hun_tens;
		digit_t hun_units;
	} digits_t;

	typedef struct packed {
		logic [TIME_W-1:0] bin;
		digits_t           dig;
	} time_t;

	typedef struct packed {
		time_t shown;
		logic  running;
	} result_t;

	// Segment pattern, bit0 = a .. bit6 = g; non-decimal codes stay blank
	function automatic logic [SEG_W-1:0] seg_of(input digit_t d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/swl_core.sv =====
// Run state, pending tick, elapsed and lap registers of the lap stopwatch.
// Depends on swl_pkg; time is kept both as a binary count and as decimal digits.
module swl_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [swl_pkg::BTN_W-1:0]    buttons,
	input  logic                         show_lap,
	input  logic                         tick,
	output swl_pkg::result_t             res
);
	import swl_pkg::*;

	time_t elapsed_q, lap_q;
	logic  run_q, pend_q;

	time_t elapsed_clr, lap_n, elapsed_n, elapsed_inc;
	logic  run_n, pend_any, step, pend_n;

	// Advance the binary count and the decimal digits by one hundredth with carries
	always_comb begin
		elapsed_inc = elapsed_clr;
		elapsed_inc.bin = elapsed_clr.bin + 1'b1;
		if (elapsed_clr.dig.hun_units != 4'd9) begin
			elapsed_inc.dig.hun_units = elapsed_clr.dig.hun_units + 1'b1;
		end else begin
			elapsed_inc.dig.hun_units = '0;
			if (elapsed_clr.dig.hun_tens != 4'd9) begin
				elapsed_inc.dig.hun_tens = elapsed_clr.dig.hun_tens + 1'b1;
			end else begin
				elapsed_inc.dig.hun_tens = '0;
				if (elapsed_clr.dig.sec_units != 4'd9) begin
					elapsed_inc.dig.sec_units = elapsed_clr.dig.sec_units + 1'b1;
				end else begin
					elapsed_inc.dig.sec_units = '0;
					if (elapsed_clr.dig.sec_tens != 4'd5) begin
						elapsed_inc.dig.sec_tens = elapsed_clr.dig.sec_tens + 1'b1;
					end else begin
						elapsed_inc.dig.sec_tens = '0;
						if (elapsed_clr.dig.min_units != 4'd9) begin
							elapsed_inc.dig.min_units = elapsed_clr.dig.min_units + 1'b1;
						end else begin
							elapsed_inc.dig.min_units = '0;
							elapsed_inc.dig.min_tens = (elapsed_clr.dig.min_tens == 4'd5) ?
								4'd0 : elapsed_clr.dig.min_tens + 1'b1;
						end
					end
				end
			end
		end
		// Wrap at the limit
		if (elapsed_clr.bin == WRAP_LAST) begin
			elapsed_inc = '0;
		end
	end

	always_comb begin
		pend_any    = pend_q | tick;
		run_n       = (run_q | buttons[BTN_START]) & ~buttons[BTN_STOP];
		lap_n       = buttons[BTN_LAP] ? elapsed_q : lap_q;
		elapsed_clr = elapsed_q;
		if (buttons[BTN_CLEAR]) begin
			lap_n       = '0;
			elapsed_clr = '0;
		end
		step      = run_n & pend_any;
		pend_n    = pend_any & ~step;
		elapsed_n = step ? elapsed_inc : elapsed_clr;

		res.shown   = show_lap ? lap_n : elapsed_n;
		res.running = run_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			lap_q     <= '0;
			run_q     <= 1'b0;
			pend_q    <= 1'b0;
		end else if (en) begin
			elapsed_q <= elapsed_n;
			lap_q     <= lap_n;
			run_q     <= run_n;
			pend_q    <= pend_n;
		end
	end

endmodule

// ===== hw/rtl/swl_seg.sv =====
// Seven-segment patterns for the six displayed digits (mm:ss:hh).
// Depends on swl_pkg for the digit type and the segment encoder.
module swl_seg (
	input  swl_pkg::digits_t dig,
	output logic [15:0]      hex_upper,
	output logic [31:0]      hex_lower
);
	import swl_pkg::*;

	assign hex_upper = {1'b0, seg_of(dig.min_tens), 1'b0, seg_of(dig.min_units)};
	assign hex_lower = {1'b0, seg_of(dig.sec_tens), 1'b0, seg_of(dig.sec_units),
	                    1'b0, seg_of(dig.hun_tens), 1'b0, seg_of(dig.hun_units)};

endmodule

// ===== hw/rtl/stopwatch_lap_seven_segment.sv =====
// Lap stopwatch with six-digit seven-segment output. Each input transfer is one
// poll of the buttons (start, stop, lap, clear, handled in that order with stop
// winning over start), the lap/current display switch and the hundredth-second
// tick event; each poll yields exactly one output transfer with the mm:ss:hh
// segment patterns, the shown time in hundredths and the run state. A tick that
// arrives while stopped stays pending until a poll in which the watch runs, and
// the time wraps to zero at one hour. Rate: one poll per clock cycle while the
// output is not stalled. The input register feeds the state update and segment
// decode, which land in the output register. Time is counted in binary and in
// decimal digits side by side, so no divider sits in the path. Backpressure on
// the output stalls the whole pipe; the input stage still takes one poll while a
// result waits.
// Depends on swl_pkg, swl_core and swl_seg.
module stopwatch_lap_seven_segment (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] buttons, [4] show_lap, [5] tick, [7:6] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [15:0] hex_upper, [47:16] hex_lower,
	                               // [66:48] shown_time, [67] is_running, [71:68] zero
);
	import swl_pkg::*;

	// Input stage
	logic             valid_s1;
	logic [BTN_W-1:0] buttons_s1;
	logic             show_lap_s1, tick_s1;

	// Output stage
	logic              valid_s2;
	logic [15:0]       hex_upper_s2;
	logic [31:0]       hex_lower_s2;
	logic [TIME_W-1:0] shown_time_s2;
	logic              running_s2;

	logic        adv, upd;
	result_t     res;
	logic [15:0] hex_upper;
	logic [31:0] hex_lower;

	// Advance the output stage whenever it is empty or being drained
	assign adv      = !valid_s2 || m_tready;
	assign upd      = adv && valid_s1;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			buttons_s1  <= s_tdata[3:0];
			show_lap_s1 <= s_tdata[4];
			tick_s1     <= s_tdata[5];
		end
	end

	// State update: commits only when the poll moves to the output stage
	swl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (upd),
		.buttons  (buttons_s1),
		.show_lap (show_lap_s1),
		.tick     (tick_s1),
		.res      (res)
	);

	swl_seg u_seg (
		.dig       (res.shown.dig),
		.hex_upper (hex_upper),
		.hex_lower (hex_lower)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			hex_upper_s2  <= hex_upper;
			hex_lower_s2  <= hex_lower;
			shown_time_s2 <= res.shown.bin;
			running_s2    <= res.running;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0, running_s2, shown_time_s2, hex_lower_s2, hex_upper_s2};

	// Shown time never reaches the wrap limit
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(shown_time_s2) < 32'(WRAP_LIMIT)))
		else $error("shown time beyond wrap limit");

	// Decimal digits track the binary count
	a_digits_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (32'(res.shown.bin) ==
			32'(res.shown.dig.min_tens) * 60000 + 32'(res.shown.dig.min_units) * 6000 +
			32'(res.shown.dig.sec_tens) * 1000 + 32'(res.shown.dig.sec_units) * 100 +
			32'(res.shown.dig.hun_tens) * 10 + 32'(res.shown.dig.hun_units)))
		else $error("digit counters out of step with binary time");

	// Stop pressed in a committed poll leaves the watch stopped
	a_stop_wins: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && buttons_s1[BTN_STOP]) |=> (m_tvalid && !running_s2))
		else $error("watch running after stop");

	// Output stage only moves forward when it is free or drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(shown_time_s2)))
		else $error("pending result overwritten");

endmodule

// ===== sim/stopwatch_lap_seven_segment_tb.sv =====
// Self-checking testbench for the lap stopwatch with seven-segment output.
// Depends on swl_pkg and the stopwatch_lap_seven_segment RTL; runs directed,
// random, output hold-off and steady counting tests against its own watch model.
`timescale 1ns / 100ps

module stopwatch_lap_seven_segment_tb;
	import swl_pkg::*;

	localparam int          CYCLE_LIMIT    = 1500000;
	localparam int          HUND_PER_MIN   = 6000;
	localparam int          HUND_PER_SEC   = 100;
	localparam int          RANDOM_POLLS   = 1750;
	localparam int          HOLD_POLLS     = 50;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          STEADY_POLLS   = 130;
	localparam int          MAX_REPORTS    = 40;
	localparam logic [3:0]  PRESS_NONE     = 4'b0000;
	localparam logic [3:0]  PRESS_START    = 4'(1 << BTN_START);
	localparam logic [3:0]  PRESS_STOP     = 4'(1 << BTN_STOP);
	localparam logic [3:0]  PRESS_LAP      = 4'(1 << BTN_LAP);
	localparam logic [3:0]  PRESS_CLEAR    = 4'(1 << BTN_CLEAR);

	// Segment patterns, bit0 = a .. bit6 = g
	localparam logic [6:0] SEG_TABLE [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	typedef struct packed {
		logic [15:0]       hex_upper;
		logic [31:0]       hex_lower;
		logic [TIME_W-1:0] shown_time;
		logic              is_running;
	} display_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [3:0] buttons, [4] show_lap, [5] tick, [7:6] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // [15:0] hex_upper, [47:16] hex_lower,
	                             // [66:48] shown_time, [67] is_running, [71:68] zero

	// Watch model state, mirrors the block after each accepted poll
	logic [TIME_W-1:0] elapsed_time  = '0;
	logic [TIME_W-1:0] lap_mark      = '0;
	logic              watch_running = 1'b0;
	logic              tick_waiting  = 1'b0;

	display_t expected_displays [$];
	display_t oldest_display;

	bit idle_on     = 1'b1;
	int hold_cycles = 0;
	int cycle_count = 0;
	int mismatch_count  = 0;
	int polls_sent      = 0;
	int results_checked = 0;
	int ticks_consumed  = 0;
	int wraps_seen      = 0;

	stopwatch_lap_seven_segment u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [6:0] seg_pattern(input int digit);
		// Out-of-range digits stay blank
		return (digit >= 0 && digit < 10) ? SEG_TABLE[digit] : 7'h00;
	endfunction

	// Apply one poll to the watch model and return the display it should give.
	// Order matters: tick latch, start, stop, lap, clear, then tick consume.
	function automatic display_t advance_watch(input logic [3:0] btn, input logic lap_sel,
	                                           input logic tk);
		display_t          d;
		logic [TIME_W-1:0] t;
		int                mins;
		int                secs;
		int                hund;
		if (tk)
			tick_waiting = 1'b1;
		if (btn[BTN_START])
			watch_running = 1'b1;
		if (btn[BTN_STOP])
			watch_running = 1'b0;
		if (btn[BTN_LAP])
			lap_mark = elapsed_time;
		if (btn[BTN_CLEAR]) begin
			elapsed_time = '0;
			lap_mark     = '0;
		end
		if (watch_running && tick_waiting) begin
			tick_waiting = 1'b0;
			ticks_consumed++;
			if (elapsed_time == TIME_W'(WRAP_LIMIT - 1)) begin
				elapsed_time = '0;
				wraps_seen++;
			end else begin
				elapsed_time = elapsed_time + 1'b1;
			end
		end
		t    = lap_sel ? lap_mark : elapsed_time;
		mins = int'(t) / HUND_PER_MIN;
		secs = (int'(t) / HUND_PER_SEC) % 60;
		hund = int'(t) % HUND_PER_SEC;
		d.hex_upper  = {1'b0, seg_pattern(mins / 10), 1'b0, seg_pattern(mins % 10)};
		d.hex_lower  = {1'b0, seg_pattern(secs / 10), 1'b0, seg_pattern(secs % 10),
		                1'b0, seg_pattern(hund / 10), 1'b0, seg_pattern(hund % 10)};
		d.shown_time = t;
		d.is_running = watch_running;
		return d;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned want,
	                               input longint unsigned got);
		if (mismatch_count < MAX_REPORTS)
			$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		mismatch_count++;
	endtask

	// Offer one poll; entered and left at a falling edge. Random gaps drop
	// tvalid first, then hold the item until the transfer completes.
	task automatic send_poll(input logic [3:0] btn, input logic lap_sel, input logic tk);
		while (idle_on && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, tk, lap_sel, btn};
		do
			@(posedge clk);
		while (!s_tready);
		expected_displays.push_back(advance_watch(btn, lap_sel, tk));
		polls_sent++;
		@(negedge clk);
	endtask

	// Mostly running with ticks, with occasional presses of any combination
	task automatic random_poll();
		logic [3:0] btn;
		int         r;
		r = $urandom_range(99);
		if (r < 8)
			btn = 4'($urandom_range(15));
		else if (r < 12)
			btn = PRESS_START;
		else if (r < 15)
			btn = PRESS_STOP;
		else if (r < 18)
			btn = PRESS_LAP;
		else if (r < 20)
			btn = PRESS_CLEAR;
		else
			btn = PRESS_NONE;
		send_poll(btn, 1'($urandom_range(1)), 1'($urandom_range(99) < 70));
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready    <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= idle_on ? ($urandom_range(99) >= 6) : 1'b1;
		end
	end

	// Compare every output transfer with the oldest expected display
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_displays.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, m_tdata[63:0]);
			end else begin
				oldest_display = expected_displays.pop_front();
				if (m_tdata[15:0] !== oldest_display.hex_upper)
					report_mismatch("hex_upper", 64'(oldest_display.hex_upper),
					                64'(m_tdata[15:0]));
				if (m_tdata[47:16] !== oldest_display.hex_lower)
					report_mismatch("hex_lower", 64'(oldest_display.hex_lower),
					                64'(m_tdata[47:16]));
				if (m_tdata[66:48] !== oldest_display.shown_time)
					report_mismatch("shown_time", 64'(oldest_display.shown_time),
					                64'(m_tdata[66:48]));
				if (m_tdata[67] !== oldest_display.is_running)
					report_mismatch("is_running", 64'(oldest_display.is_running),
					                64'(m_tdata[67]));
				if (m_tdata[71:68] !== 4'b0000)
					report_mismatch("tdata padding", 64'd0, 64'(m_tdata[71:68]));
			end
			results_checked++;
		end
	end

	// Watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			         expected_displays.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Display right after reset, both sources
	task automatic test_idle_display();
		send_poll(PRESS_NONE, 1'b0, 1'b0);
		send_poll(PRESS_NONE, 1'b1, 1'b0);
	endtask

	// Button ordering and tick bookkeeping corner cases
	task automatic test_button_order();
		// tick while stopped stays pending; a second one merges into it
		send_poll(PRESS_NONE, 1'b0, 1'b1);
		send_poll(PRESS_NONE, 1'b0, 1'b1);
		// start consumes the pending tick in the same poll
		send_poll(PRESS_START, 1'b0, 1'b0);
		send_poll(PRESS_NONE, 1'b0, 1'b1);
		send_poll(PRESS_NONE, 1'b0, 1'b0);
		// start and stop together: stop wins, tick left pending
		send_poll(PRESS_START | PRESS_STOP, 1'b0, 1'b1);
		// lap takes the time from before the tick
		send_poll(PRESS_START | PRESS_LAP, 1'b1, 1'b0);
		send_poll(PRESS_LAP, 1'b0, 1'b1);
		send_poll(PRESS_NONE, 1'b1, 1'b0);
		// lap with clear ends with a zero lap
		send_poll(PRESS_LAP | PRESS_CLEAR, 1'b1, 1'b1);
		send_poll(PRESS_CLEAR, 1'b0, 1'b0);
		// clear while stopped keeps the pending tick and the run state
		send_poll(PRESS_STOP, 1'b0, 1'b1);
		send_poll(PRESS_CLEAR, 1'b0, 1'b0);
		// every button at once
		send_poll(PRESS_START | PRESS_STOP | PRESS_LAP | PRESS_CLEAR, 1'b1, 1'b1);
		send_poll(PRESS_START, 1'b0, 1'b0);
		send_poll(PRESS_STOP | PRESS_CLEAR, 1'b1, 1'b0);
	endtask

	// Random polls with a stretch of clean back-to-back traffic in the middle
	task automatic test_random_polls();
		for (int i = 0; i < RANDOM_POLLS; i++) begin
			idle_on = !(i >= 800 && i < 1100);
			random_poll();
		end
		idle_on = 1'b1;
	endtask

	// Hold the output off long enough for the pipe to fill and stall the input
	task automatic test_backpressure();
		hold_cycles = HOLD_CYCLES;
		for (int i = 0; i < HOLD_POLLS; i++)
			random_poll();
	endtask

	// Count from zero with a tick on every poll, across the one-second carry
	task automatic test_steady_count();
		idle_on = 1'b0;
		send_poll(PRESS_START | PRESS_CLEAR, 1'b0, 1'b0);
		for (int i = 0; i < STEADY_POLLS; i++)
			send_poll(PRESS_NONE, 1'($urandom_range(1)), 1'b1);
		send_poll(PRESS_LAP, 1'b1, 1'b0);
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_display();
		test_button_order();
		test_random_polls();
		test_backpressure();
		test_steady_count();

		// Drop tvalid, drain, then let the pipe settle
		s_tvalid <= 1'b0;
		while (expected_displays.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d polls and checked %0d displays in %0d cycles.", polls_sent,
		         results_checked, cycle_count);
		$display("Model counted %0d ticks and %0d hour wraps; %0d mismatches.", ticks_consumed,
		         wraps_seen, mismatch_count);
		if (mismatch_count == 0 && expected_displays.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
